// ===== rtl/hsvrgb_pkg.sv =====
// Shared types and constants for the HSV to RGB converter.
package hsvrgb_pkg;

    // Field widths.
    localparam int HUE_W  = 11;
    localparam int CHAN_W = 8;
    localparam int NUM_W  = 16;

    // One full turn of hue: six sectors of 256 steps.
    localparam logic [HUE_W-1:0] HUE_FULL_TURN = 11'd1536;

    // 255 * 256, the scale of the q and t numerators, and half of it for rounding.
    localparam logic [NUM_W-1:0] FRAC_SCALE = 16'd65280;
    localparam logic [NUM_W-1:0] FRAC_HALF  = 16'd32640;

    // Rounding offset for the p term, which is scaled by 255 only.
    localparam logic [NUM_W-1:0] P_HALF = 16'd127;

    // Full-scale channel value.
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Hue sectors, named by the color at their start.
    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

    // Side information that travels down the pipeline with each pixel.
    typedef struct packed {
        sector_t            sector;
        logic [CHAN_W-1:0]  val;
    } pix_ctl_t;

endpackage

// ===== rtl/hsvrgb_front.sv =====
// Front end of the converter: hue decode, saturation products and scaled numerators.
module hsvrgb_front (
    input  logic                         clk,
    input  logic                         en_s1,
    input  logic                         en_s2,
    input  logic [hsvrgb_pkg::HUE_W-1:0]  hue_in,
    input  logic [hsvrgb_pkg::CHAN_W-1:0] sat_in,
    input  logic [hsvrgb_pkg::CHAN_W-1:0] val_in,
    output logic [hsvrgb_pkg::NUM_W-1:0]  num_p,
    output logic [hsvrgb_pkg::NUM_W-1:0]  num_q,
    output logic [hsvrgb_pkg::NUM_W-1:0]  num_t,
    output hsvrgb_pkg::pix_ctl_t          ctl
);
    import hsvrgb_pkg::*;

    logic [HUE_W-1:0]   hue_wrap;
    logic [CHAN_W-1:0]  frac;
    logic [CHAN_W:0]    frac_inv;
    logic [NUM_W-1:0]   sf_next;
    logic [NUM_W-1:0]   st_next;
    logic [NUM_W-1:0]   sf_reg;
    logic [NUM_W-1:0]   st_reg;
    logic [CHAN_W-1:0]  sat_inv_next;
    logic [CHAN_W-1:0]  sat_inv_reg;
    pix_ctl_t           ctl_next;
    pix_ctl_t           ctl1_reg;

    logic [NUM_W-1:0]        coef_q;
    logic [NUM_W-1:0]        coef_t;
    logic [NUM_W-1:0]        prod_p;
    logic [NUM_W+CHAN_W-1:0] prod_q;
    logic [NUM_W+CHAN_W-1:0] prod_t;
    logic [NUM_W+CHAN_W-1:0] sum_q;
    logic [NUM_W+CHAN_W-1:0] sum_t;
    logic [NUM_W-1:0]        num_p_next;
    logic [NUM_W-1:0]        num_q_next;
    logic [NUM_W-1:0]        num_t_next;
    logic [NUM_W-1:0]        num_p_reg;
    logic [NUM_W-1:0]        num_q_reg;
    logic [NUM_W-1:0]        num_t_reg;
    pix_ctl_t                ctl2_reg;

    // Stage 1: a hue at or past a full turn wraps to red, then split into sector and fraction.
    always_comb
    begin
        hue_wrap        = (hue_in >= HUE_FULL_TURN) ? '0 : hue_in;
        frac            = hue_wrap[CHAN_W-1:0];
        frac_inv        = 9'd256 - {1'b0, frac};
        sf_next         = {8'd0, sat_in} * {8'd0, frac};
        st_next         = {8'd0, sat_in} * {7'd0, frac_inv};
        sat_inv_next    = CHAN_MAX - sat_in;
        ctl_next.sector = sector_t'(hue_wrap[HUE_W-1:CHAN_W]);
        ctl_next.val    = val_in;
    end

    always_ff @(posedge clk)
    begin
        if (en_s1)
        begin
            sf_reg      <= sf_next;
            st_reg      <= st_next;
            sat_inv_reg <= sat_inv_next;
            ctl1_reg    <= ctl_next;
        end
    end

    // Stage 2: scale by value and add the rounding half; q and t drop their factor of 256.
    always_comb
    begin
        coef_q     = FRAC_SCALE - sf_reg;
        coef_t     = FRAC_SCALE - st_reg;
        prod_p     = {8'd0, ctl1_reg.val} * {8'd0, sat_inv_reg};
        prod_q     = {16'd0, ctl1_reg.val} * {8'd0, coef_q};
        prod_t     = {16'd0, ctl1_reg.val} * {8'd0, coef_t};
        sum_q      = prod_q + {8'd0, FRAC_HALF};
        sum_t      = prod_t + {8'd0, FRAC_HALF};
        num_p_next = prod_p + P_HALF;
        num_q_next = sum_q[NUM_W+CHAN_W-1:CHAN_W];
        num_t_next = sum_t[NUM_W+CHAN_W-1:CHAN_W];
    end

    always_ff @(posedge clk)
    begin
        if (en_s2)
        begin
            num_p_reg <= num_p_next;
            num_q_reg <= num_q_next;
            num_t_reg <= num_t_next;
            ctl2_reg  <= ctl1_reg;
        end
    end

    assign num_p = num_p_reg;
    assign num_q = num_q_reg;
    assign num_t = num_t_reg;
    assign ctl   = ctl2_reg;

endmodule

// ===== rtl/hsvrgb_div255.sv =====
// Division of a 16-bit numerator by 255 through a reciprocal multiply and one correction.
module hsvrgb_div255 (
    input  logic                         clk,
    input  logic                         en,
    input  logic [hsvrgb_pkg::NUM_W-1:0]  num,
    output logic [hsvrgb_pkg::CHAN_W-1:0] quo
);
    import hsvrgb_pkg::*;

    logic [NUM_W+CHAN_W-1:0] recip_prod;
    logic [CHAN_W-1:0]       est_next;
    logic [CHAN_W-1:0]       est_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [NUM_W-1:0]        est_times;
    logic [NUM_W-1:0]        rem;

    // Estimate num * 257 / 65536; it is never above the true quotient and at most one below.
    always_comb
    begin
        recip_prod = {8'd0, num} * 24'd257;
        est_next   = recip_prod[NUM_W+CHAN_W-1:NUM_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            est_reg <= est_next;
            num_reg <= num;
        end
    end

    // Correct the estimate when the remainder still holds a whole 255.
    always_comb
    begin
        est_times = ({8'd0, est_reg} << CHAN_W) - {8'd0, est_reg};
        rem       = num_reg - est_times;
        quo       = (rem >= {8'd0, CHAN_MAX}) ? est_reg + 8'd1 : est_reg;
    end

endmodule

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB converter: a four-stage pipeline taking one pixel request per clock
// while out_ready lets the output drain; throughput is then one pixel per cycle,
// set by the fully pipelined multiply stages.
// Each stage stalls only when it is full and the stage after it cannot advance.
// Reset clears all valid bits; payload registers are not reset.
module hsv_to_rgb_converter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0]  hue_in,
    input  logic [hsvrgb_pkg::CHAN_W-1:0] sat_in,
    input  logic [hsvrgb_pkg::CHAN_W-1:0] val_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [hsvrgb_pkg::CHAN_W-1:0] red_out,
    output logic [hsvrgb_pkg::CHAN_W-1:0] green_out,
    output logic [hsvrgb_pkg::CHAN_W-1:0] blue_out
);
    import hsvrgb_pkg::*;

    logic s1_vld_reg;
    logic s2_vld_reg;
    logic s3_vld_reg;
    logic s4_vld_reg;
    logic en_s1;
    logic en_s2;
    logic en_s3;
    logic en_s4;

    logic [NUM_W-1:0]  num_p;
    logic [NUM_W-1:0]  num_q;
    logic [NUM_W-1:0]  num_t;
    pix_ctl_t          ctl2;
    pix_ctl_t          ctl3_reg;
    logic [CHAN_W-1:0] chan_p;
    logic [CHAN_W-1:0] chan_q;
    logic [CHAN_W-1:0] chan_t;

    logic [CHAN_W-1:0] red_next;
    logic [CHAN_W-1:0] green_next;
    logic [CHAN_W-1:0] blue_next;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;

    // A stage may load when it is empty or its contents move on in the same cycle.
    assign en_s4    = !s4_vld_reg || out_ready;
    assign en_s3    = !s3_vld_reg || en_s4;
    assign en_s2    = !s2_vld_reg || en_s3;
    assign en_s1    = !s1_vld_reg || en_s2;
    assign in_ready = en_s1;

    // Valid bits follow the data down the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            if (en_s1)
            begin
                s1_vld_reg <= in_valid;
            end
            if (en_s2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (en_s3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (en_s4)
            begin
                s4_vld_reg <= s3_vld_reg;
            end
        end
    end

    // Stages 1 and 2: hue decode and the p, q, t numerators.
    hsvrgb_front u_front (
        .clk    (clk),
        .en_s1  (en_s1),
        .en_s2  (en_s2),
        .hue_in (hue_in),
        .sat_in (sat_in),
        .val_in (val_in),
        .num_p  (num_p),
        .num_q  (num_q),
        .num_t  (num_t),
        .ctl    (ctl2)
    );

    // Stage 3: one divide-by-255 unit per term.
    hsvrgb_div255 u_div_p (
        .clk (clk),
        .en  (en_s3),
        .num (num_p),
        .quo (chan_p)
    );

    hsvrgb_div255 u_div_q (
        .clk (clk),
        .en  (en_s3),
        .num (num_q),
        .quo (chan_q)
    );

    hsvrgb_div255 u_div_t (
        .clk (clk),
        .en  (en_s3),
        .num (num_t),
        .quo (chan_t)
    );

    always_ff @(posedge clk)
    begin
        if (en_s3)
        begin
            ctl3_reg <= ctl2;
        end
    end

    // Stage 4: route p, q, t and value to the channels by sector.
    // Zero saturation needs no special path, since p, q and t all equal value then.
    always_comb
    begin
        unique case (ctl3_reg.sector)
            SEC_RED:
            begin
                red_next   = ctl3_reg.val;
                green_next = chan_t;
                blue_next  = chan_p;
            end
            SEC_YELLOW:
            begin
                red_next   = chan_q;
                green_next = ctl3_reg.val;
                blue_next  = chan_p;
            end
            SEC_GREEN:
            begin
                red_next   = chan_p;
                green_next = ctl3_reg.val;
                blue_next  = chan_t;
            end
            SEC_CYAN:
            begin
                red_next   = chan_p;
                green_next = chan_q;
                blue_next  = ctl3_reg.val;
            end
            SEC_BLUE:
            begin
                red_next   = chan_t;
                green_next = chan_p;
                blue_next  = ctl3_reg.val;
            end
            default:
            begin
                red_next   = ctl3_reg.val;
                green_next = chan_p;
                blue_next  = chan_q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en_s4)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = s4_vld_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule
